@@ rtl/core/ffba_pkg.sv @@
// Shared types and codes of the first-fit block allocator.
// Used by the allocator top level and its table memory wiring.
`default_nettype none
package ffba_pkg;

  // Operation codes of an input item
  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_LEN        = 3'd2,
    OP_REALLOC    = 3'd3,
    OP_LOAD_USED  = 3'd4,
    OP_LOAD_FREE  = 3'd5
  } op_t;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_POOL_START = 1'b0;
  localparam logic CFG_POOL_END   = 1'b1;

  // Cell rounding constants
  localparam logic [31:0] CELL_MASK   = 32'd15;
  localparam logic [31:0] MIN_BYTES   = 32'd4;
  localparam logic [31:0] MAX_REQUEST = 32'hFFFF_FFF0;

  // One table entry as stored in the table memory
  typedef struct packed {
    logic        used;
    logic [31:0] size;
    logic [31:0] addr;
  } entry_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_ASTART,
    S_ARD,
    S_ACHK,
    S_ASPL,
    S_AAPP,
    S_ABUMP,
    S_AOK,
    S_FRD,
    S_FCHK,
    S_FCLR,
    S_CIRD,
    S_CICHK,
    S_CJRD,
    S_CJCHK,
    S_CSRD,
    S_CSWR,
    S_CIWR,
    S_LOAD,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/ffba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the allocator's block table.
`default_nettype none
module ffba_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, and read port registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/core/first_fit_block_allocator.sv @@
// First-fit block allocator: sequencer, pool registers and result register.
// Depends on ffba_pkg and ffba_ram (block table).
//
// Usage: one operation enters per transfer on the in_ channel (alloc, free,
// length query, realloc, load used entry, load free entry) and gives exactly
// one result transfer on the out_ channel. The user must write the pool bounds on
// the cfg_ port only while the block is idle; the block itself does not enforce
// this. Writing pool_start also reloads the bump pointer.
// Sequencing: the block table sits in a RAM with one read and one write port and
// registered read data, and one sequencer walks it with a read state and a check
// state per entry. An alloc scans the entries for a first fit and else carves
// from the pool at the bump pointer; a free adds a coalescing pass with an inner
// compare walk and removal shifts. A load appends one entry. in_tready is high
// only while the sequencer is idle, so one operation is in work at a time.
// Reset: the table is empty, the bump pointer holds 32'h5300_0000 and the pool end
// 32'h5380_0000; the table RAM needs no clearing since only entries below the count are read.
// Stall: a finished result waits in the output register; the next operation
// is accepted and worked on meanwhile, and only its own result waits until
// the register is free.
`default_nettype none
module first_fit_block_allocator #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // operation[2:0], block_address[34:3], byte_count[66:35], zero fill
  input  wire logic [71:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // result_address[31:0], result_length[63:32], moved[64], status[67:65]
  output logic      [71:0] out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

  ffba_pkg::state_t state_r, state_nxt;
  ffba_pkg::op_t    op_r, op_nxt;
  logic [31:0]      a_r, a_nxt, n_r, n_nxt, need_r, need_nxt;
  logic [31:0]      cur_a_r, cur_a_nxt, cur_s_r, cur_s_nxt, old_r, old_nxt;
  logic [CW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, cnt_r, cnt_nxt;
  logic             rphase_r, rphase_nxt;
  logic [31:0]      bump_r, bump_nxt, pend_r;
  logic [31:0]      raddr_r, raddr_nxt, rlen_r, rlen_nxt;
  logic             moved_r, moved_nxt;
  logic [2:0]       st_r, st_nxt;

  logic             out_valid_r;
  logic [31:0]      out_raddr_r, out_rlen_r;
  logic             out_moved_r;
  logic [2:0]       out_st_r;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  ffba_pkg::entry_t    ram_wdata, rd;
  logic [$bits(ffba_pkg::entry_t)-1:0] ram_rdata;

  // Cell rounding of the latched request
  logic [31:0] n_min, need;
  logic        oversize, cnt_full, is_free;
  logic [32:0] bump_end;

  assign n_min    = (n_r < ffba_pkg::MIN_BYTES) ? ffba_pkg::MIN_BYTES : n_r;
  assign need     = (n_min + ffba_pkg::CELL_MASK) & ~ffba_pkg::CELL_MASK;
  assign oversize = n_r > ffba_pkg::MAX_REQUEST;
  assign cnt_full = cnt_r >= CNT_MAX;
  assign is_free  = (op_r == ffba_pkg::OP_FREE) ||
                    ((op_r == ffba_pkg::OP_REALLOC) && ((n_r == 32'd0) || rphase_r));
  assign bump_end = {1'b0, bump_r} + {1'b0, need_r};
  assign rd       = ffba_pkg::entry_t'(ram_rdata);

  ffba_ram #(
    .WIDTH ($bits(ffba_pkg::entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ffba_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_st_r, out_moved_r, out_rlen_r, out_raddr_r};

  // Read address of the entry after k, kept to the index width
  function automatic logic [IW-1:0] k_nxt_read(input logic [CW-1:0] k);
    logic [CW-1:0] kp;
    kp = k + 1'b1;
    return kp[IW-1:0];
  endfunction

  // Sequencer: next state, table accesses and working registers
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    n_nxt      = n_r;
    need_nxt   = need_r;
    cur_a_nxt  = cur_a_r;
    cur_s_nxt  = cur_s_r;
    old_nxt    = old_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    rphase_nxt = rphase_r;
    bump_nxt   = bump_r;
    raddr_nxt  = raddr_r;
    rlen_nxt   = rlen_r;
    moved_nxt  = moved_r;
    st_nxt     = st_r;
    ram_we     = 1'b0;
    ram_waddr  = i_r[IW-1:0];
    ram_wdata  = '0;
    ram_raddr  = i_r[IW-1:0];

    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = ffba_pkg::op_t'(in_tdata[2:0]);
          a_nxt      = in_tdata[34:3];
          n_nxt      = in_tdata[66:35];
          raddr_nxt  = '0;
          rlen_nxt   = '0;
          moved_nxt  = 1'b0;
          st_nxt     = ffba_pkg::ST_OK;
          rphase_nxt = 1'b0;
          i_nxt      = '0;
          unique case (in_tdata[2:0])
            ffba_pkg::OP_ALLOC: state_nxt = ffba_pkg::S_ASTART;
            ffba_pkg::OP_FREE:
              state_nxt = (in_tdata[34:3] == 32'd0) ? ffba_pkg::S_DONE : ffba_pkg::S_FRD;
            ffba_pkg::OP_LEN: state_nxt = ffba_pkg::S_FRD;
            ffba_pkg::OP_REALLOC:
              state_nxt = (in_tdata[34:3] == 32'd0) ? ffba_pkg::S_ASTART : ffba_pkg::S_FRD;
            ffba_pkg::OP_LOAD_USED, ffba_pkg::OP_LOAD_FREE: begin
              if ((in_tdata[34:3] == 32'd0) || (in_tdata[66:35] == 32'd0)) begin
                st_nxt    = ffba_pkg::ST_REJECT;
                state_nxt = ffba_pkg::S_DONE;
              end else if (cnt_full) begin
                st_nxt    = ffba_pkg::ST_FULL;
                state_nxt = ffba_pkg::S_DONE;
              end else begin
                state_nxt = ffba_pkg::S_LOAD;
              end
            end
            default: state_nxt = ffba_pkg::S_DONE;
          endcase
        end
      end

      // Append a loaded entry
      ffba_pkg::S_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IW-1:0];
        ram_wdata = '{used: (op_r == ffba_pkg::OP_LOAD_USED), size: n_r, addr: a_r};
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ffba_pkg::S_DONE;
      end

      // Alloc: round the request and start the first-fit scan
      ffba_pkg::S_ASTART: begin
        if (oversize) begin
          st_nxt    = ffba_pkg::ST_NOSPACE;
          state_nxt = ffba_pkg::S_DONE;
        end else begin
          need_nxt  = need;
          i_nxt     = '0;
          state_nxt = ffba_pkg::S_ARD;
        end
      end

      ffba_pkg::S_ARD: begin
        state_nxt = (i_r >= cnt_r) ? ffba_pkg::S_ABUMP : ffba_pkg::S_ACHK;
      end

      ffba_pkg::S_ACHK: begin
        if (!rd.used && (rd.size >= need_r)) begin
          cur_a_nxt = rd.addr;
          cur_s_nxt = rd.size;
          if ((rd.size != need_r) && ((rd.addr + need_r) == 32'd0)) begin
            st_nxt    = ffba_pkg::ST_NOSPACE;
            state_nxt = ffba_pkg::S_DONE;
          end else if ((rd.size != need_r) && cnt_full) begin
            st_nxt    = ffba_pkg::ST_FULL;
            state_nxt = ffba_pkg::S_DONE;
          end else begin
            state_nxt = ffba_pkg::S_ASPL;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ffba_pkg::S_ARD;
        end
      end

      // Mark the fitting entry used, trimmed to the rounded size
      ffba_pkg::S_ASPL: begin
        ram_we    = 1'b1;
        ram_wdata = '{used: 1'b1, size: need_r, addr: cur_a_r};
        state_nxt = (cur_s_r != need_r) ? ffba_pkg::S_AAPP : ffba_pkg::S_AOK;
      end

      // Append the remainder as a free entry
      ffba_pkg::S_AAPP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IW-1:0];
        ram_wdata = '{used: 1'b0, size: cur_s_r - need_r, addr: cur_a_r + need_r};
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ffba_pkg::S_AOK;
      end

      // Carve from the pool at the bump pointer
      ffba_pkg::S_ABUMP: begin
        if ((bump_end > {1'b0, pend_r}) || (bump_r == 32'd0)) begin
          st_nxt    = ffba_pkg::ST_NOSPACE;
          state_nxt = ffba_pkg::S_DONE;
        end else if (cnt_full) begin
          st_nxt    = ffba_pkg::ST_FULL;
          state_nxt = ffba_pkg::S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[IW-1:0];
          ram_wdata = '{used: 1'b1, size: need_r, addr: bump_r};
          cnt_nxt   = cnt_r + 1'b1;
          cur_a_nxt = bump_r;
          bump_nxt  = bump_end[31:0];
          state_nxt = ffba_pkg::S_AOK;
        end
      end

      // Alloc granted; a realloc goes on to free the old block
      ffba_pkg::S_AOK: begin
        raddr_nxt = cur_a_r;
        if (rphase_r) begin
          moved_nxt = 1'b1;
          rlen_nxt  = (old_r < n_r) ? old_r : n_r;
          i_nxt     = '0;
          state_nxt = ffba_pkg::S_FRD;
        end else begin
          state_nxt = ffba_pkg::S_DONE;
        end
      end

      // Search for the used entry at the given address
      ffba_pkg::S_FRD: begin
        if (i_r >= cnt_r) begin
          st_nxt    = ffba_pkg::ST_NOTFOUND;
          state_nxt = ffba_pkg::S_DONE;
        end else begin
          state_nxt = ffba_pkg::S_FCHK;
        end
      end

      ffba_pkg::S_FCHK: begin
        if (rd.used && (rd.addr == a_r)) begin
          if (op_r == ffba_pkg::OP_LEN) begin
            rlen_nxt  = rd.size;
            state_nxt = ffba_pkg::S_DONE;
          end else if (is_free) begin
            cur_a_nxt = rd.addr;
            cur_s_nxt = rd.size;
            state_nxt = ffba_pkg::S_FCLR;
          end else begin
            old_nxt = rd.size;
            if (oversize) begin
              st_nxt    = ffba_pkg::ST_NOSPACE;
              state_nxt = ffba_pkg::S_DONE;
            end else if (need <= rd.size) begin
              raddr_nxt = a_r;
              state_nxt = ffba_pkg::S_DONE;
            end else begin
              need_nxt   = need;
              rphase_nxt = 1'b1;
              i_nxt      = '0;
              state_nxt  = ffba_pkg::S_ARD;
            end
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ffba_pkg::S_FRD;
        end
      end

      // Clear the used mark and start coalescing
      ffba_pkg::S_FCLR: begin
        ram_we    = 1'b1;
        ram_wdata = '{used: 1'b0, size: cur_s_r, addr: cur_a_r};
        i_nxt     = '0;
        state_nxt = ffba_pkg::S_CIRD;
      end

      // Coalescing: outer walk over free entries
      ffba_pkg::S_CIRD: begin
        state_nxt = (i_r >= cnt_r) ? ffba_pkg::S_DONE : ffba_pkg::S_CICHK;
      end

      ffba_pkg::S_CICHK: begin
        if (rd.used) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ffba_pkg::S_CIRD;
        end else begin
          cur_a_nxt = rd.addr;
          cur_s_nxt = rd.size;
          j_nxt     = i_r + 1'b1;
          state_nxt = ffba_pkg::S_CJRD;
        end
      end

      // Inner walk: look for a free neighbour in address
      ffba_pkg::S_CJRD: begin
        ram_raddr = j_r[IW-1:0];
        state_nxt = (j_r >= cnt_r) ? ffba_pkg::S_CIWR : ffba_pkg::S_CJCHK;
      end

      ffba_pkg::S_CJCHK: begin
        if (!rd.used && ((cur_a_r + cur_s_r) == rd.addr)) begin
          cur_s_nxt = cur_s_r + rd.size;
          k_nxt     = j_r;
          state_nxt = ffba_pkg::S_CSRD;
        end else if (!rd.used && ((rd.addr + rd.size) == cur_a_r)) begin
          cur_a_nxt = rd.addr;
          cur_s_nxt = cur_s_r + rd.size;
          k_nxt     = j_r;
          state_nxt = ffba_pkg::S_CSRD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ffba_pkg::S_CJRD;
        end
      end

      // Remove entry j: shift the tail down one place
      ffba_pkg::S_CSRD: begin
        ram_raddr = k_nxt_read(k_r);
        if ((k_r + 1'b1) >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ffba_pkg::S_CJRD;
        end else begin
          state_nxt = ffba_pkg::S_CSWR;
        end
      end

      ffba_pkg::S_CSWR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        ram_wdata = rd;
        k_nxt     = k_r + 1'b1;
        state_nxt = ffba_pkg::S_CSRD;
      end

      // Write back the merged entry i
      ffba_pkg::S_CIWR: begin
        ram_we    = 1'b1;
        ram_wdata = '{used: 1'b0, size: cur_s_r, addr: cur_a_r};
        i_nxt     = i_r + 1'b1;
        state_nxt = ffba_pkg::S_CIRD;
      end

      // Hand the result to the output register once it is free
      ffba_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ffba_pkg::S_IDLE;
        end
      end

      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ffba_pkg::S_IDLE;
      cnt_r    <= '0;
      rphase_r <= 1'b0;
      pend_r   <= 32'h5380_0000;
      bump_r   <= 32'h5300_0000;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rphase_r <= rphase_nxt;
      if (cfg_we && (cfg_index == ffba_pkg::CFG_POOL_START)) begin
        bump_r   <= cfg_wdata;
      end else begin
        bump_r   <= bump_nxt;
      end
      if (cfg_we && (cfg_index == ffba_pkg::CFG_POOL_END)) begin
        pend_r <= cfg_wdata;
      end
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    n_r     <= n_nxt;
    need_r  <= need_nxt;
    cur_a_r <= cur_a_nxt;
    cur_s_r <= cur_s_nxt;
    old_r   <= old_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    raddr_r <= raddr_nxt;
    rlen_r  <= rlen_nxt;
    moved_r <= moved_nxt;
    st_r    <= st_nxt;
  end

  // Output register: load on completion, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ffba_pkg::S_DONE) && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ffba_pkg::S_DONE) && (!out_valid_r || out_tready)) begin
      out_raddr_r <= raddr_r;
      out_rlen_r  <= rlen_r;
      out_moved_r <= moved_r;
      out_st_r    <= st_r;
    end
  end

  // The table never holds more entries than it has room for
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("entry count beyond table depth");

  // No table write while an operation is being taken in
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !ram_we)
    else $error("table written while idle");

  // A result appears only after the sequencer has finished
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ffba_pkg::S_DONE))
    else $error("result without finished operation");

  // A moved realloc always reports success
  a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_moved_r) |-> (out_st_r == ffba_pkg::ST_OK))
    else $error("moved block with failure status");

endmodule
`default_nettype wire
